[hw/rtl/assert_macros.svh]
// Assertion macros shared by the collision velocity resolver RTL.
// Sampled on clk_i and disabled while rst_ni is low; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define CVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define CVR_ASSERT(lbl, prop, msg)
`define CVR_ASSERT_IMP(lbl, ante, cons, msg)
`define CVR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/cvr_pkg.sv]
// Package for the collision velocity resolver: sequencer state and step codes.
// No dependencies; used by collision_velocity_resolver_unit.
`timescale 1ns / 1ps
package cvr_pkg;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_RES   = 8'b0001_0000,
    ST_ACC   = 8'b0010_0000,
    ST_OUT0  = 8'b0100_0000,
    ST_OUT1  = 8'b1000_0000
  } cvr_state_e;

  typedef enum logic [4:0] {
    STEP_NNX, STEP_NNY, STEP_VNX, STEP_VNY,
    STEP_PARX, STEP_PARY,
    STEP_OPX, STEP_EPX, STEP_FX,
    STEP_OPY, STEP_EPY, STEP_FY,
    STEP_EVX, STEP_EVY,
    STEP_AX, STEP_AY
  } cvr_step_e;

endpackage

[hw/rtl/collision_velocity_resolver_unit.sv]
// Two-body 2D collision response: sequencer, operand routing and result registers.
// Depends on cvr_pkg, cvr_mul, cvr_div and assert_macros.svh.
//
// Usage: bodies arrive on the s_axis stream, one body per transfer. A transfer
// with s_axis_tuser low holds the first body (no result; a later one replaces
// it). A transfer with s_axis_tuser high completes the pair, brings the contact
// normal and yields two results on m_axis: first body then second, the second
// with m_axis_tlast high. A completing body with no held body is dropped.
// time_step is written on the cfg channel, always ready.
// A completing body runs a program of shift-add multiplies and restoring
// divides, all on the single shared multiplier and divider; with both bodies
// fixed it runs no program. s_axis_tready stays low from the completing
// transfer until the second result is taken.
// Reset clears the held body and restores time_step to 1/60.
// A stalled receiver holds each result on m_axis until it is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module collision_velocity_resolver_unit #(
  parameter int WORD_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: velocity_x, velocity_y, position_x, position_y, body_mass,
  //        restitution, friction_coef, is_fixed, normal_x, normal_y
  input  logic                                                  s_axis_tvalid,
  output logic                                                  s_axis_tready,
  input  logic [((7*WORD_WIDTH+2*FRACTION_BITS+3+7)/8)*8-1:0]   s_axis_tdata,
  // tuser: second_body
  input  logic                                                  s_axis_tuser,
  output logic                                                  m_axis_tvalid,
  input  logic                                                  m_axis_tready,
  // tdata: new_velocity_x, new_velocity_y, new_position_x, new_position_y,
  //        changed, zero_normal
  output logic [((4*WORD_WIDTH+2+7)/8)*8-1:0]                   m_axis_tdata,
  // tuser: which_body
  output logic                                                  m_axis_tuser,
  output logic                                                  m_axis_tlast,
  input  logic                                                  cfg_valid_i,
  output logic                                                  cfg_ready_o,
  input  logic [WORD_WIDTH-1:0]                                 cfg_data_i
);
  localparam int W      = WORD_WIDTH;
  localparam int F      = FRACTION_BITS;
  localparam int CW     = F + 1;
  localparam int MA     = 2 * W + 1;
  localparam int BS     = W + 3;
  localparam int PW     = MA + BS;
  localparam int SW     = PW + 1;
  localparam int DW     = 2 * W;
  localparam int OUT_TW = ((4 * W + 2 + 7) / 8) * 8;
  localparam int OFF_M  = 4 * W;
  localparam int OFF_E  = 5 * W;
  localparam int OFF_F  = 5 * W + CW;
  localparam int OFF_X  = 5 * W + 2 * CW;
  localparam int OFF_NX = OFF_X + 1;
  localparam int OFF_NY = OFF_NX + W;
  localparam logic [W-1:0]  DT_RESET = W'((64'(1) << F) / 60);
  localparam logic [CW:0]   ONE_C    = (CW + 1)'(1) << F;

  cvr_pkg::cvr_state_e state_q, state_d;
  cvr_pkg::cvr_step_e  step_q, step_d;

  logic [W-1:0]  dt_q;
  logic          held_valid_q;
  logic [W-1:0]  h_vx_q, h_vy_q, h_px_q, h_py_q, h_m_q;
  logic [CW-1:0] h_e_q, h_f_q;
  logic          h_fix_q;
  logic [W-1:0]  b_vx_q, b_vy_q, b_px_q, b_py_q, b_m_q, nx_q, ny_q;
  logic [CW-1:0] e_q, f_q;
  logic          cur_q, free2_q, zn_q, chg0_q, chg1_q;
  logic [W-1:0]  nvx0_q, nvy0_q, npx0_q, npy0_q, nvx1_q, nvy1_q, npx1_q, npy1_q;
  logic [DW-1:0] nn_q;
  logic [MA-1:0] vn_q, t_q;
  logic [BS-1:0] parx_q, pary_q, perpx_q, perpy_q;
  logic [SW-1:0] r_q;

  logic [W-1:0]  in_vx, in_vy, in_px, in_py, in_m;
  logic [CW-1:0] in_e, in_f;
  logic          in_fix;
  logic          in_acc, first_take, pair_start;
  logic [W-1:0]  c_vx, c_vy, c_px, c_py, c_m, o_vx, o_vy, o_m, c_nvx, c_nvy;
  logic [CW:0]   omf;
  logic [MA-1:0] op_a;
  logic [BS-1:0] op_b;
  logic [DW-1:0] op_den;
  logic          op_div, op_shr;
  logic          mul_start, mul_busy, mul_neg, div_start, div_busy;
  logic [PW-1:0] mul_prod, div_quo, mag_sel, mag_s;
  logic [W-1:0]  sat_r, sat_p;

  function automatic logic [MA-1:0] sxa(input logic [W-1:0] v);
    sxa = {{(MA - W){v[W-1]}}, v};
  endfunction

  function automatic logic [BS-1:0] sxb(input logic [W-1:0] v);
    sxb = {{(BS - W){v[W-1]}}, v};
  endfunction

  function automatic logic [W-1:0] sat_w(input logic [SW-1:0] v);
    logic fits;
    fits  = (&v[SW-1:W-1]) || !(|v[SW-1:W-1]);
    sat_w = fits ? v[W-1:0] : (v[SW-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}});
  endfunction

  assign in_vx  = s_axis_tdata[0 +: W];
  assign in_vy  = s_axis_tdata[W +: W];
  assign in_px  = s_axis_tdata[2 * W +: W];
  assign in_py  = s_axis_tdata[3 * W +: W];
  assign in_m   = s_axis_tdata[OFF_M +: W];
  assign in_e   = s_axis_tdata[OFF_E +: CW];
  assign in_f   = s_axis_tdata[OFF_F +: CW];
  assign in_fix = s_axis_tdata[OFF_X];

  assign s_axis_tready = (state_q == cvr_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign first_take    = in_acc && !s_axis_tuser;
  assign pair_start    = in_acc && s_axis_tuser && held_valid_q;
  assign cfg_ready_o   = 1'b1;

  assign c_vx  = cur_q ? b_vx_q : h_vx_q;
  assign c_vy  = cur_q ? b_vy_q : h_vy_q;
  assign c_px  = cur_q ? b_px_q : h_px_q;
  assign c_py  = cur_q ? b_py_q : h_py_q;
  assign c_m   = cur_q ? b_m_q : h_m_q;
  assign o_vx  = cur_q ? h_vx_q : b_vx_q;
  assign o_vy  = cur_q ? h_vy_q : b_vy_q;
  assign o_m   = cur_q ? h_m_q : b_m_q;
  assign c_nvx = cur_q ? nvx1_q : nvx0_q;
  assign c_nvy = cur_q ? nvy1_q : nvy0_q;
  assign omf   = ONE_C - {1'b0, f_q};

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_den = '0;
    op_div = 1'b0;
    op_shr = 1'b0;
    unique case (step_q)
      cvr_pkg::STEP_NNX: begin op_a = sxa(nx_q); op_b = sxb(nx_q); end
      cvr_pkg::STEP_NNY: begin op_a = sxa(ny_q); op_b = sxb(ny_q); end
      cvr_pkg::STEP_VNX: begin op_a = sxa(c_vx); op_b = sxb(nx_q); end
      cvr_pkg::STEP_VNY: begin op_a = sxa(c_vy); op_b = sxb(ny_q); end
      cvr_pkg::STEP_PARX: begin
        op_a = vn_q; op_b = sxb(nx_q); op_div = 1'b1; op_den = nn_q;
      end
      cvr_pkg::STEP_PARY: begin
        op_a = vn_q; op_b = sxb(ny_q); op_div = 1'b1; op_den = nn_q;
      end
      cvr_pkg::STEP_OPX: begin op_a = {{(MA - CW - 1){omf[CW]}}, omf}; op_b = perpx_q; end
      cvr_pkg::STEP_OPY: begin op_a = {{(MA - CW - 1){omf[CW]}}, omf}; op_b = perpy_q; end
      cvr_pkg::STEP_EPX: begin op_a = MA'(e_q); op_b = parx_q; end
      cvr_pkg::STEP_EPY: begin op_a = MA'(e_q); op_b = pary_q; end
      cvr_pkg::STEP_FX, cvr_pkg::STEP_FY: begin
        op_a = t_q; op_b = BS'(1); op_shr = 1'b1;
      end
      cvr_pkg::STEP_EVX: begin
        op_a = sxa(o_vx); op_b = BS'(o_m); op_div = 1'b1; op_den = DW'(c_m);
      end
      cvr_pkg::STEP_EVY: begin
        op_a = sxa(o_vy); op_b = BS'(o_m); op_div = 1'b1; op_den = DW'(c_m);
      end
      cvr_pkg::STEP_AX: begin op_a = sxa(c_nvx); op_b = BS'(dt_q); op_shr = 1'b1; end
      cvr_pkg::STEP_AY: begin op_a = sxa(c_nvy); op_b = BS'(dt_q); op_shr = 1'b1; end
      default: begin end
    endcase
  end

  assign mul_start = (state_q == cvr_pkg::ST_START);
  assign div_start = (state_q == cvr_pkg::ST_MUL) && !mul_busy && op_div;
  assign mag_sel   = op_div ? ((mul_prod == '0) ? '0 : div_quo) : mul_prod;
  assign mag_s     = op_shr ? (mag_sel >> F) : mag_sel;
  assign sat_r     = sat_w(r_q);
  assign sat_p     = sat_w(r_q + {{(SW - W){(step_q == cvr_pkg::STEP_AX) ? c_px[W-1] : c_py[W-1]}},
                                  (step_q == cvr_pkg::STEP_AX) ? c_px : c_py});

  cvr_mul #(.MA(MA), .BS(BS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .busy_o  (mul_busy),
    .neg_o   (mul_neg),
    .prod_o  (mul_prod)
  );

  cvr_div #(.NW(PW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod),
    .den_i   (op_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      cvr_pkg::ST_IDLE: begin
        if (pair_start) begin
          if (h_fix_q && in_fix) begin
            state_d = cvr_pkg::ST_OUT0;
          end else if (h_fix_q || in_fix) begin
            state_d = cvr_pkg::ST_START;
            step_d  = cvr_pkg::STEP_NNX;
          end else begin
            state_d = cvr_pkg::ST_START;
            step_d  = cvr_pkg::STEP_EVX;
          end
        end
      end
      cvr_pkg::ST_START: state_d = cvr_pkg::ST_MUL;
      cvr_pkg::ST_MUL: begin
        if (!mul_busy) state_d = op_div ? cvr_pkg::ST_DIV : cvr_pkg::ST_RES;
      end
      cvr_pkg::ST_DIV: begin
        if (!div_busy) state_d = cvr_pkg::ST_RES;
      end
      cvr_pkg::ST_RES: state_d = cvr_pkg::ST_ACC;
      cvr_pkg::ST_ACC: begin
        state_d = cvr_pkg::ST_START;
        unique case (step_q)
          cvr_pkg::STEP_NNX:  step_d = cvr_pkg::STEP_NNY;
          cvr_pkg::STEP_NNY:  step_d = cvr_pkg::STEP_VNX;
          cvr_pkg::STEP_VNX:  step_d = cvr_pkg::STEP_VNY;
          cvr_pkg::STEP_VNY:  step_d = (nn_q == '0) ? cvr_pkg::STEP_OPX : cvr_pkg::STEP_PARX;
          cvr_pkg::STEP_PARX: step_d = cvr_pkg::STEP_PARY;
          cvr_pkg::STEP_PARY: step_d = cvr_pkg::STEP_OPX;
          cvr_pkg::STEP_OPX:  step_d = cvr_pkg::STEP_EPX;
          cvr_pkg::STEP_EPX:  step_d = cvr_pkg::STEP_FX;
          cvr_pkg::STEP_FX:   step_d = cvr_pkg::STEP_OPY;
          cvr_pkg::STEP_OPY:  step_d = cvr_pkg::STEP_EPY;
          cvr_pkg::STEP_EPY:  step_d = cvr_pkg::STEP_FY;
          cvr_pkg::STEP_FY:   step_d = cvr_pkg::STEP_AX;
          cvr_pkg::STEP_EVX:  step_d = cvr_pkg::STEP_EVY;
          cvr_pkg::STEP_EVY:  step_d = cvr_pkg::STEP_AX;
          cvr_pkg::STEP_AX:   step_d = cvr_pkg::STEP_AY;
          cvr_pkg::STEP_AY: begin
            if (free2_q && !cur_q) step_d = cvr_pkg::STEP_EVX;
            else state_d = cvr_pkg::ST_OUT0;
          end
          default: state_d = cvr_pkg::ST_IDLE;
        endcase
      end
      cvr_pkg::ST_OUT0: begin
        if (m_axis_tready) state_d = cvr_pkg::ST_OUT1;
      end
      cvr_pkg::ST_OUT1: begin
        if (m_axis_tready) state_d = cvr_pkg::ST_IDLE;
      end
      default: state_d = cvr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cvr_pkg::ST_IDLE;
      step_q       <= cvr_pkg::STEP_NNX;
      dt_q         <= DT_RESET;
      held_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_valid_i) dt_q <= cfg_data_i;
      if (first_take) held_valid_q <= 1'b1;
      else if (pair_start) held_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (first_take) begin
      h_vx_q <= in_vx; h_vy_q <= in_vy; h_px_q <= in_px; h_py_q <= in_py;
      h_m_q  <= in_m;  h_e_q  <= in_e;  h_f_q  <= in_f;  h_fix_q <= in_fix;
    end
    if (pair_start) begin
      b_vx_q  <= in_vx; b_vy_q <= in_vy; b_px_q <= in_px; b_py_q <= in_py; b_m_q <= in_m;
      nx_q    <= s_axis_tdata[OFF_NX +: W];
      ny_q    <= s_axis_tdata[OFF_NY +: W];
      e_q     <= (h_e_q < in_e) ? h_e_q : in_e;
      f_q     <= (h_f_q > in_f) ? h_f_q : in_f;
      cur_q   <= h_fix_q && !in_fix;
      free2_q <= !h_fix_q && !in_fix;
      zn_q    <= 1'b0;
      chg0_q  <= !h_fix_q;
      chg1_q  <= !in_fix;
      nvx0_q  <= h_vx_q; nvy0_q <= h_vy_q; npx0_q <= h_px_q; npy0_q <= h_py_q;
      nvx1_q  <= in_vx;  nvy1_q <= in_vy;  npx1_q <= in_px;  npy1_q <= in_py;
    end
    if (state_q == cvr_pkg::ST_RES) begin
      r_q <= mul_neg ? (~{1'b0, mag_s} + 1'b1) : {1'b0, mag_s};
    end
    if (state_q == cvr_pkg::ST_ACC) begin
      unique case (step_q)
        cvr_pkg::STEP_NNX: nn_q <= r_q[DW-1:0];
        cvr_pkg::STEP_NNY: nn_q <= nn_q + r_q[DW-1:0];
        cvr_pkg::STEP_VNX: vn_q <= r_q[MA-1:0];
        cvr_pkg::STEP_VNY: begin
          vn_q <= vn_q + r_q[MA-1:0];
          if (nn_q == '0) begin
            zn_q    <= 1'b1;
            parx_q  <= '0;
            pary_q  <= '0;
            perpx_q <= sxb(c_vx);
            perpy_q <= sxb(c_vy);
          end
        end
        cvr_pkg::STEP_PARX: begin
          parx_q  <= r_q[BS-1:0];
          perpx_q <= sxb(c_vx) - r_q[BS-1:0];
        end
        cvr_pkg::STEP_PARY: begin
          pary_q  <= r_q[BS-1:0];
          perpy_q <= sxb(c_vy) - r_q[BS-1:0];
        end
        cvr_pkg::STEP_OPX, cvr_pkg::STEP_OPY: t_q <= r_q[MA-1:0];
        cvr_pkg::STEP_EPX, cvr_pkg::STEP_EPY: t_q <= t_q - r_q[MA-1:0];
        cvr_pkg::STEP_FX, cvr_pkg::STEP_EVX: begin
          if (cur_q) nvx1_q <= sat_r;
          else nvx0_q <= sat_r;
        end
        cvr_pkg::STEP_FY, cvr_pkg::STEP_EVY: begin
          if (cur_q) nvy1_q <= sat_r;
          else nvy0_q <= sat_r;
        end
        cvr_pkg::STEP_AX: begin
          if (cur_q) npx1_q <= sat_p;
          else npx0_q <= sat_p;
        end
        cvr_pkg::STEP_AY: begin
          if (cur_q) npy1_q <= sat_p;
          else npy0_q <= sat_p;
          if (free2_q && !cur_q) cur_q <= 1'b1;
        end
        default: begin end
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == cvr_pkg::ST_OUT0) || (state_q == cvr_pkg::ST_OUT1);
  assign m_axis_tlast  = (state_q == cvr_pkg::ST_OUT1);
  assign m_axis_tuser  = (state_q == cvr_pkg::ST_OUT1);
  assign m_axis_tdata  = (state_q == cvr_pkg::ST_OUT1)
      ? OUT_TW'({zn_q, chg1_q, npy1_q, npx1_q, nvy1_q, nvx1_q})
      : OUT_TW'({zn_q, chg0_q, npy0_q, npx0_q, nvy0_q, nvx0_q});

  `CVR_ASSERT(a_units_excl, !(mul_busy && div_busy), "multiplier and divider busy together")
  `CVR_ASSERT_IMP(a_out_quiet, m_axis_tvalid, !mul_busy && !div_busy, "result shown mid-op")
  `CVR_ASSERT_NXT(a_out_order, (state_q == cvr_pkg::ST_OUT0) && m_axis_tready, (state_q == cvr_pkg::ST_OUT1), "second result skipped")
  `CVR_ASSERT_NXT(a_pair_clear, pair_start, !held_valid_q, "held body kept after pair")
endmodule

[hw/rtl/cvr_mul.sv]
// Shift-add multiplier, sign-magnitude result, one multiplier bit per cycle.
// Standalone; instantiated by collision_velocity_resolver_unit.
`timescale 1ns / 1ps
module cvr_mul #(
  parameter int MA = 65,
  parameter int BS = 35
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MA-1:0]       a_i,
  input  logic [BS-1:0]       b_i,
  output logic                busy_o,
  output logic                neg_o,
  output logic [MA+BS-1:0]    prod_o
);
  localparam int PW   = MA + BS;
  localparam int CNTW = $clog2(BS + 1);

  logic [MA-1:0]   a_mag_q;
  logic [PW-1:0]   p_q;
  logic            neg_q;
  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [MA-1:0]   a_abs;
  logic [BS-1:0]   b_abs;
  logic [MA:0]     sum;

  assign a_abs = a_i[MA-1] ? (~a_i + 1'b1) : a_i;
  assign b_abs = b_i[BS-1] ? (~b_i + 1'b1) : b_i;
  assign sum   = {1'b0, p_q[PW-1:BS]} + (p_q[0] ? {1'b0, a_mag_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(BS);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CNTW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_mag_q <= a_abs;
      p_q     <= {{MA{1'b0}}, b_abs};
      neg_q   <= a_i[MA-1] ^ b_i[BS-1];
    end else if (busy_q) begin
      p_q <= {sum, p_q[BS-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign neg_o  = neg_q;
  assign prod_o = p_q;
endmodule

[hw/rtl/cvr_div.sv]
// Restoring divider, unsigned, one quotient bit per cycle.
// Standalone; instantiated by collision_velocity_resolver_unit.
`timescale 1ns / 1ps
module cvr_div #(
  parameter int NW = 100,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   n_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            ge;

  assign rem_sh = {rem_q, n_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NW);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CNTW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      n_q   <= {n_q[NW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = n_q;
endmodule
